// File: rtl/tmce_pkg.sv
// ----------------------------------------------------------------------------
// tmce_pkg: shared types and constants of the text console engine
// Request and result payloads, the decoded command passed from the front end
// to the back end, configuration codes and the back end state encoding.
// ----------------------------------------------------------------------------
package tmce_pkg;

  // Request modes.
  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_MOVE  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  // Control characters handled by put-character requests.
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FG    = 2'd0;
  localparam logic [1:0] CFG_BG    = 2'd1;
  localparam logic [1:0] CFG_LEFT  = 2'd2;
  localparam logic [1:0] CFG_RIGHT = 2'd3;

  localparam int CELL_W = 16;

  // Command queue depth; must be a power of two so the pointers wrap freely.
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] char_code;
    logic [6:0] target_col;
    logic [4:0] target_row;
  } req_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_linear;
    logic        scrolled;
    logic [7:0]  cell_char;
    logic [7:0]  cell_color;
  } rsp_t;

  typedef struct packed {
    logic [3:0] fg_color;
    logic [3:0] bg_color;
    logic [6:0] left_margin;
    logic [6:0] right_margin;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    fg_color:     4'd7,
    bg_color:     4'd0,
    left_margin:  7'd0,
    right_margin: 7'd80
  };

  typedef enum logic [3:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_RETURN,
    OP_FORMFEED,
    OP_TAB,
    OP_BACKSPACE,
    OP_MOVE,
    OP_CLEAR,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] char_code;
    logic [6:0] target_col;
    logic [4:0] target_row;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic ready;
  } back_status_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_BLANK,
    ST_FILL,
    ST_REPORT
  } back_state_t;

endpackage

// File: rtl/tmce_ram.sv
// ----------------------------------------------------------------------------
// tmce_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tmce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/tmce_front.sv
// ----------------------------------------------------------------------------
// tmce_front: request intake and classification
// Accepts requests while the queue has room and the screen is initialized,
// and turns each one into a decoded command for the back end.
// ----------------------------------------------------------------------------
module tmce_front import tmce_pkg::*; (
  input  req_t         req,
  input  logic         req_valid,
  output logic         req_ready,
  input  q_status_t    q_status,
  input  back_status_t back_status,
  output cmd_t         q_cmd,
  output logic         q_push
);

  assign req_ready = !q_status.full && back_status.ready;
  assign q_push    = req_valid && req_ready;

  always_comb begin
    q_cmd.char_code  = req.char_code;
    q_cmd.target_col = req.target_col;
    q_cmd.target_row = req.target_row;
    unique case (req.mode)
      MODE_PUT: begin
        unique case (req.char_code)
          CH_LF:   q_cmd.op = OP_NEWLINE;
          CH_CR:   q_cmd.op = OP_RETURN;
          CH_FF:   q_cmd.op = OP_FORMFEED;
          CH_TAB:  q_cmd.op = OP_TAB;
          CH_BS:   q_cmd.op = OP_BACKSPACE;
          default: q_cmd.op = OP_PUT;
        endcase
      end
      MODE_MOVE:  q_cmd.op = OP_MOVE;
      MODE_CLEAR: q_cmd.op = OP_CLEAR;
      MODE_READ:  q_cmd.op = OP_READ;
      default:    q_cmd.op = OP_READ;
    endcase
  end

endmodule

// File: rtl/tmce_queue.sv
// ----------------------------------------------------------------------------
// tmce_queue: command queue between front end and back end
// A short FIFO of decoded commands so that intake and execution stall
// independently.
// ----------------------------------------------------------------------------
module tmce_queue import tmce_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      push_cmd,
  input  logic      push,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t status
);

  cmd_t           entries [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign head         = entries[rd_ptr];
  assign status.full  = (count == (QAW+1)'(QDEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      if (push && !pop) begin
        count <= count + (QAW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QAW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: rtl/tmce_back.sv
// ----------------------------------------------------------------------------
// tmce_back: command execution
// Runs one command at a time: cursor arithmetic, cell writes and reads, and
// the walks over the screen memory for scroll, clear and the power-up fill.
// ----------------------------------------------------------------------------
module tmce_back import tmce_pkg::*; #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  cmd_t         q_head,
  input  q_status_t    q_status,
  output logic         q_pop,
  output back_status_t status,
  output rsp_t         rsp,
  output logic         rsp_valid,
  input  logic         rsp_ready
);

  localparam int NCELLS = COLUMNS * ROWS;
  localparam int CW     = $clog2(COLUMNS);
  localparam int RW     = $clog2(ROWS);
  localparam int AW     = $clog2(NCELLS);
  localparam int XW     = $clog2(COLUMNS + TAB_WIDTH + 1);
  localparam int YW     = $clog2(ROWS + 2);
  localparam int TSW    = $clog2(TAB_WIDTH + 1);

  localparam logic [AW-1:0] LAST_CELL = AW'(NCELLS - 1);
  localparam logic [AW-1:0] COPY_END  = AW'(NCELLS - COLUMNS);
  localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);

  back_state_t state, state_next;
  logic [AW-1:0] ptr, ptr_next;
  cmd_t          cur;
  logic [CW-1:0] cur_col, col_next;
  logic [RW-1:0] cur_row, row_next;
  logic          scr_flag, scr_next;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [CELL_W-1:0] ram_rdata;

  logic [7:0]     attr;
  logic [XW-1:0]  eff_l, eff_r;
  logic [CW-1:0]  sat_col;
  logic [RW-1:0]  sat_row;
  logic [AW-1:0]  cur_lin, sat_lin;
  logic [XW-1:0]  col_a, col_b;
  logic [YW-1:0]  line_a, line_b;
  logic           scroll_hit;
  logic           pop_ok;
  logic [TSW-1:0] tab_step [2**CW];

  logic [CW+6:0]  col_w;
  logic [RW+4:0]  row_w;
  logic [AW+10:0] lin_w;

  tmce_ram #(
    .WIDTH (CELL_W),
    .DEPTH (NCELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Distance to the next tab stop for every column value.
  for (genvar g = 0; g < 2**CW; g++) begin : g_tab
    localparam int STEP = TAB_WIDTH - (g % TAB_WIDTH);
    assign tab_step[g] = TSW'(STEP);
  end

  assign attr          = {cfg.bg_color, cfg.fg_color};
  assign status.ready  = (state != ST_INIT);
  assign pop_ok        = !q_status.empty && (!rsp_valid || rsp_ready);
  assign cur_lin       = AW'(cur_row) * ROW_STEP + AW'(cur_col);
  assign sat_lin       = AW'(sat_row) * ROW_STEP + AW'(sat_col);

  // Margins as actually used: the left one saturates, the right one is kept
  // strictly above the left one and within the screen.
  always_comb begin
    if (32'(cfg.left_margin) > COLUMNS - 1) begin
      eff_l = XW'(COLUMNS - 1);
    end else begin
      eff_l = XW'(cfg.left_margin);
    end
    if (cfg.right_margin == '0) begin
      eff_r = XW'(1);
    end else if (32'(cfg.right_margin) > COLUMNS) begin
      eff_r = XW'(COLUMNS);
    end else begin
      eff_r = XW'(cfg.right_margin);
    end
    if (eff_r <= eff_l) begin
      eff_r = eff_l + XW'(1);
    end
  end

  always_comb begin
    if (32'(cur.target_col) > COLUMNS - 1) begin
      sat_col = COL_LAST;
    end else begin
      sat_col = CW'(cur.target_col);
    end
    if (32'(cur.target_row) > ROWS - 1) begin
      sat_row = ROW_LAST;
    end else begin
      sat_row = RW'(cur.target_row);
    end
  end

  // Cursor movement of put-character commands, then wrap and scroll check.
  always_comb begin
    col_a  = XW'(cur_col);
    line_a = YW'(cur_row);
    case (cur.op)
      OP_NEWLINE: begin
        col_a  = eff_l;
        line_a = YW'(cur_row) + YW'(1);
      end
      OP_RETURN: begin
        col_a = eff_l;
      end
      OP_FORMFEED: begin
        line_a = YW'(cur_row) + YW'(1);
      end
      OP_TAB: begin
        col_a = XW'(cur_col) + XW'(tab_step[cur_col]);
      end
      OP_BACKSPACE: begin
        if (XW'(cur_col) <= eff_l) begin
          if (cur_row != '0) begin
            col_a  = eff_r - XW'(1);
            line_a = YW'(cur_row) - YW'(1);
          end
        end else begin
          col_a = XW'(cur_col) - XW'(1);
        end
      end
      default: begin
        col_a = XW'(cur_col) + XW'(1);
      end
    endcase

    col_b  = col_a;
    line_b = line_a;
    if (col_a >= eff_r) begin
      col_b  = col_a - (eff_r - eff_l);
      line_b = line_a + YW'(1);
      if (col_b >= eff_r) begin
        col_b = eff_l;
      end
    end
    scroll_hit = (line_b >= YW'(ROWS));
  end

  always_comb begin
    col_next = cur_col;
    row_next = cur_row;
    scr_next = 1'b0;
    unique case (cur.op) inside
      OP_PUT, OP_NEWLINE, OP_RETURN, OP_FORMFEED, OP_TAB, OP_BACKSPACE: begin
        col_next = CW'(col_b);
        row_next = scroll_hit ? ROW_LAST : RW'(line_b);
        scr_next = scroll_hit;
      end
      OP_MOVE: begin
        col_next = sat_col;
        row_next = sat_row;
      end
      OP_CLEAR: begin
        col_next = '0;
        row_next = '0;
      end
      default: begin
        col_next = cur_col;
        row_next = cur_row;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (ptr == LAST_CELL) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop_ok) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (cur.op) inside
          OP_PUT, OP_NEWLINE, OP_RETURN, OP_FORMFEED, OP_TAB, OP_BACKSPACE: begin
            state_next = scroll_hit ? ST_SCROLL : ST_REPORT;
          end
          OP_CLEAR: state_next = ST_FILL;
          default:  state_next = ST_REPORT;
        endcase
      end
      ST_SCROLL: begin
        if (ptr == COPY_END) begin
          state_next = ST_BLANK;
        end
      end
      ST_BLANK, ST_FILL: begin
        if (ptr == LAST_CELL) begin
          state_next = ST_REPORT;
        end
      end
      ST_REPORT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Walk pointer. The scroll copy holds on its last step so the blank fill
  // starts at the first cell of the bottom row.
  always_comb begin
    unique case (state)
      ST_INIT, ST_FILL, ST_BLANK: ptr_next = (ptr == LAST_CELL) ? '0 : ptr + AW'(1);
      ST_SCROLL:                  ptr_next = (ptr == COPY_END) ? ptr : ptr + AW'(1);
      default:                    ptr_next = '0;
    endcase
  end

  // Memory and queue controls.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    q_pop     = 1'b0;
    unique case (state)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = ptr;
      end
      ST_IDLE: begin
        q_pop = pop_ok;
      end
      ST_EXEC: begin
        if (cur.op == OP_PUT) begin
          ram_we    = 1'b1;
          ram_waddr = cur_lin;
          ram_wdata = {attr, cur.char_code};
        end
        ram_raddr = sat_lin;
      end
      ST_SCROLL: begin
        // Read one row ahead; the cell read in the previous cycle lands one
        // row up.
        ram_raddr = (ptr == COPY_END) ? '0 : ptr + ROW_STEP;
        ram_we    = (ptr != '0);
        ram_waddr = ptr - AW'(1);
        ram_wdata = ram_rdata;
      end
      ST_BLANK, ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = ptr;
        ram_wdata = {attr, 8'h00};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign col_w = (CW+7)'(cur_col);
  assign row_w = (RW+5)'(cur_row);
  assign lin_w = (AW+11)'(cur_lin);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      ptr       <= '0;
      cur_col   <= '0;
      cur_row   <= '0;
      scr_flag  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
      if (state == ST_EXEC) begin
        cur_col  <= col_next;
        cur_row  <= row_next;
        scr_flag <= scr_next;
      end
      if (state == ST_REPORT) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if (state == ST_REPORT) begin
      rsp.cursor_col    <= col_w[6:0];
      rsp.cursor_row    <= row_w[4:0];
      rsp.cursor_linear <= lin_w[10:0];
      rsp.scrolled      <= scr_flag;
      if (cur.op == OP_READ) begin
        rsp.cell_char  <= ram_rdata[7:0];
        rsp.cell_color <= ram_rdata[15:8];
      end else begin
        rsp.cell_char  <= '0;
        rsp.cell_color <= '0;
      end
    end
  end

endmodule

// File: rtl/text_mode_console_engine_unit.sv
// ----------------------------------------------------------------------------
// text_mode_console_engine_unit: character console for a text screen
// Cursor, put and read requests pass the execute and report states of the
// back end before the result is presented; a request that scrolls adds a
// copy and blank walk over the screen RAM, and clear adds a fill walk. The
// back end runs one request at a time; the queue takes new ones while it has
// room. After reset the screen RAM is zeroed, all COLUMNS*ROWS cells (2000 at
// the defaults), while no request is accepted; configuration writes are.
// ----------------------------------------------------------------------------
module text_mode_console_engine_unit import tmce_pkg::*; #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  req_t       cmd,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  output rsp_t       rsp,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  cfg_t         cfg;
  cmd_t         push_cmd;
  cmd_t         q_head;
  logic         q_push;
  logic         q_pop;
  q_status_t    q_status;
  back_status_t back_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FG:    cfg.fg_color     <= cfg_data[3:0];
        CFG_BG:    cfg.bg_color     <= cfg_data[3:0];
        CFG_LEFT:  cfg.left_margin  <= cfg_data;
        CFG_RIGHT: cfg.right_margin <= cfg_data;
        default:   cfg <= cfg;
      endcase
    end
  end

  tmce_front u_front (
    .req         (cmd),
    .req_valid   (cmd_valid),
    .req_ready   (cmd_ready),
    .q_status    (q_status),
    .back_status (back_status),
    .q_cmd       (push_cmd),
    .q_push      (q_push)
  );

  tmce_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_cmd (push_cmd),
    .push     (q_push),
    .pop      (q_pop),
    .head     (q_head),
    .status   (q_status)
  );

  tmce_back #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_head    (q_head),
    .q_status  (q_status),
    .q_pop     (q_pop),
    .status    (back_status),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready)
  );

endmodule
